/* sv/assert_macros.svh */
// Assertion macros for the RTL files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* sv/dic_pkg.sv */
package dic_pkg;

    localparam int IDX_W  = 22;
    localparam int SECS_W = 17;
    localparam int YEAR_W = 14;
    localparam int MON_W  = 4;
    localparam int MDAY_W = 5;
    localparam int YDAY_W = 9;
    localparam int WDAY_W = 3;
    localparam int HOUR_W = 5;
    localparam int MIN_W  = 6;
    localparam int SEC_W  = 6;

    localparam int EOY_W  = 23;
    localparam int MTOT_W = 11;

    localparam logic [IDX_W-1:0]  SHORT_INDEX_LIMIT = IDX_W'(65535);
    localparam logic [IDX_W-1:0]  BASE_1900         = IDX_W'(693608);
    localparam logic [SECS_W-1:0] SECS_PER_DAY      = SECS_W'(86400);
    localparam logic [YEAR_W-1:0] REFORM_YEAR       = YEAR_W'(1752);

    // year estimate: idx * 2^32 / 365.247
    localparam int               RECIP_W     = 24;
    localparam int               RECIP_SHIFT = 32;
    localparam logic [RECIP_W-1:0] YEAR_RECIP = RECIP_W'(11759076);

    localparam logic [12:0] DIV25_MUL  = 13'd5243;
    localparam logic [15:0] DIV15_MUL  = 16'd34953;
    localparam int          DIV15_SHIFT = 19;
    localparam logic [11:0] DIV306_MUL = 12'd3427;
    localparam logic [7:0]  DIV10_MUL  = 8'd205;

    localparam int                  CFG_ADDR_W          = 3;
    localparam int                  CFG_DATA_W          = 32;
    localparam logic [CFG_ADDR_W-3:0] REG_WEEKDAY_SHIFT = '0;
    localparam logic [WDAY_W-1:0]   WEEKDAY_SHIFT_RESET = WDAY_W'(1);

    function automatic logic [7:0] div25(input logic [11:0] v);
        logic [24:0] p;
        p = 25'(v) * 25'(DIV25_MUL);
        return p[24:17];
    endfunction

    // day index of the last day of year y
    function automatic logic [EOY_W-1:0] end_of_year(input logic [YEAR_W-1:0] y);
        logic [11:0]      q4;
        logic [11:0]      q16;
        logic [EOY_W-1:0] acc;
        q4  = 12'(y >> 2);
        q16 = 12'((y - YEAR_W'(1600)) >> 4);
        acc = EOY_W'(y) * EOY_W'(365) + EOY_W'(q4);
        if (y > YEAR_W'(1700)) begin
            acc = acc - EOY_W'(div25(q4)) + EOY_W'(17);
        end
        if (y > YEAR_W'(1600)) begin
            acc = acc + EOY_W'(div25(q16));
        end
        return acc;
    endfunction

    function automatic logic is_leap(input logic [YEAR_W-1:0] y);
        logic [11:0] q4;
        logic [11:0] q16;
        logic        by4;
        logic        by100;
        logic        by400;
        q4    = 12'(y >> 2);
        q16   = 12'(y >> 4);
        by4   = (y[1:0] == 2'd0);
        by100 = by4 && (q4 == 12'(div25(q4)) * 12'd25);
        by400 = (y[3:0] == 4'd0) && (q16 == 12'(div25(q16)) * 12'd25);
        if (y <= REFORM_YEAR) begin
            return by4;
        end
        return (by4 && !by100) || by400;
    endfunction

    // fold octal digits, 8 is 1 modulo 7
    function automatic logic [WDAY_W-1:0] mod7(input logic [23:0] v);
        logic [5:0] s;
        logic [3:0] f;
        logic [3:0] g;
        s = '0;
        for (int k = 0; k < 8; k++) begin
            s = s + 6'(v[3*k +: 3]);
        end
        f = 4'(s[5:3]) + 4'(s[2:0]);
        g = 4'(f[3]) + 4'(f[2:0]);
        return (g[2:0] == 3'd7) ? 3'd0 : g[2:0];
    endfunction

endpackage

/* sv/dic_if.sv */
interface dic_in_if
    import dic_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [IDX_W-1:0]  day_index;
    logic [SECS_W-1:0] seconds_of_day;
    logic              with_time;

    modport source (output valid, output day_index, output seconds_of_day,
                    output with_time, input ready);
    modport sink   (input valid, input day_index, input seconds_of_day,
                    input with_time, output ready);
endinterface

interface dic_out_if
    import dic_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [YEAR_W-1:0] year;
    logic [MON_W-1:0]  month;
    logic [MDAY_W-1:0] day_of_month;
    logic [YDAY_W-1:0] day_of_year;
    logic [WDAY_W-1:0] weekday;
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
    logic [SEC_W-1:0]  second;

    modport source (output valid, output year, output month, output day_of_month,
                    output day_of_year, output weekday, output hour, output minute,
                    output second, input ready);
    modport sink   (input valid, input year, input month, input day_of_month,
                    input day_of_year, input weekday, input hour, input minute,
                    input second, output ready);
endinterface

/* sv/day_index_to_calendar_date_top.sv */
// Converts a day index and a second-of-day value into year, month, day of month, day of
// year, weekday and hour/minute/second. One item is taken per clock unless the output stalls
// with a full pipeline; each of the seven register stages has its own enable, so a stalled
// output holds only the stages behind it that are full and bubbles still close up. The
// year search evaluates the last day of three candidate years around a multiply estimate in
// parallel and picks the exact one in the next stage. Index zero gives zero date fields;
// indices up to 65535 count from 1900. with_time low reports noon. weekday_shift (APB, byte
// address 0, reset 1) is added to the index before the weekday is taken modulo seven; write
// it only while the block is idle.
`include "assert_macros.svh"

module day_index_to_calendar_date_top
    import dic_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    dic_in_if.sink                i_item,
    dic_out_if.source             o_result
);

    localparam int NSTG   = 7;
    localparam int PROD_W = IDX_W + RECIP_W;

    logic [WDAY_W-1:0] r_shift;
    logic [NSTG-1:0]   r_v;
    logic [NSTG-1:0]   w_en;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift <= WEEKDAY_SHIFT_RESET;
        end else if (psel && penable && pwrite &&
                     paddr[CFG_ADDR_W-1:2] == REG_WEEKDAY_SHIFT) begin
            r_shift <= pwdata[WDAY_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[CFG_ADDR_W-1:2] == REG_WEEKDAY_SHIFT) ?
                    CFG_DATA_W'(r_shift) : '0;

    // stage enables
    always_comb begin
        w_en[NSTG-1] = !r_v[NSTG-1] || o_result.ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    assign i_item.ready = w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= i_item.valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // stage 1: rebase index, wrap seconds
    logic [IDX_W-1:0]  n1_idx, r1_idx;
    logic [SECS_W-1:0] n1_secs, r1_secs;
    logic              r1_zero, r1_wt;

    assign n1_idx  = (i_item.day_index <= SHORT_INDEX_LIMIT) ?
                     i_item.day_index + BASE_1900 : i_item.day_index;
    assign n1_secs = (i_item.seconds_of_day >= SECS_PER_DAY) ?
                     i_item.seconds_of_day - SECS_PER_DAY : i_item.seconds_of_day;

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r1_idx  <= n1_idx;
            r1_secs <= n1_secs;
            r1_zero <= (i_item.day_index == '0);
            r1_wt   <= i_item.with_time;
        end
    end

    // stage 2: year estimate, weekday, total minutes
    logic [PROD_W-1:0] n2_prod;
    logic [30:0]       n2_tprod;
    logic [YEAR_W-1:0] r2_est;
    logic [WDAY_W-1:0] r2_wday;
    logic [MTOT_W-1:0] r2_mtot;
    logic [IDX_W-1:0]  r2_idx;
    logic [SECS_W-1:0] r2_secs;
    logic              r2_zero, r2_wt;

    assign n2_prod  = PROD_W'(r1_idx) * PROD_W'(YEAR_RECIP);
    assign n2_tprod = 31'(r1_secs[SECS_W-1:2]) * 31'(DIV15_MUL);

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r2_est  <= n2_prod[RECIP_SHIFT +: YEAR_W];
            r2_wday <= mod7(24'(r1_idx) + 24'(r_shift));
            r2_mtot <= n2_tprod[DIV15_SHIFT +: MTOT_W];
            r2_idx  <= r1_idx;
            r2_secs <= r1_secs;
            r2_zero <= r1_zero;
            r2_wt   <= r1_wt;
        end
    end

    // stage 3: year ends of three candidates, hour, second
    logic [24:0]       n3_hprod;
    logic [EOY_W-1:0]  r3_eoy_m, r3_eoy_0, r3_eoy_p;
    logic [HOUR_W-1:0] r3_hour;
    logic [SEC_W-1:0]  r3_sec;
    logic [MTOT_W-1:0] r3_mtot;
    logic [YEAR_W-1:0] r3_est;
    logic [WDAY_W-1:0] r3_wday;
    logic [IDX_W-1:0]  r3_idx;
    logic              r3_zero, r3_wt;

    assign n3_hprod = 25'(r2_mtot[MTOT_W-1:2]) * 25'(DIV15_MUL);

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r3_eoy_m <= end_of_year(r2_est - YEAR_W'(1));
            r3_eoy_0 <= end_of_year(r2_est);
            r3_eoy_p <= end_of_year(r2_est + YEAR_W'(1));
            r3_hour  <= n3_hprod[DIV15_SHIFT +: HOUR_W];
            r3_sec   <= SEC_W'(r2_secs - SECS_W'(r2_mtot) * SECS_W'(60));
            r3_mtot  <= r2_mtot;
            r3_est   <= r2_est;
            r3_wday  <= r2_wday;
            r3_idx   <= r2_idx;
            r3_zero  <= r2_zero;
            r3_wt    <= r2_wt;
        end
    end

    // stage 4: pick the year, day of year, minute, noon default
    logic [YEAR_W-1:0] n4_year;
    logic [EOY_W-1:0]  n4_base;
    logic [HOUR_W-1:0] n4_hour;
    logic [MIN_W-1:0]  n4_min;
    logic [SEC_W-1:0]  n4_sec;
    logic [YEAR_W-1:0] r4_year;
    logic [YDAY_W-1:0] r4_yday;
    logic [HOUR_W-1:0] r4_hour;
    logic [MIN_W-1:0]  r4_min;
    logic [SEC_W-1:0]  r4_sec;
    logic [WDAY_W-1:0] r4_wday;
    logic              r4_zero;

    always_comb begin
        if (r3_eoy_0 >= EOY_W'(r3_idx)) begin
            n4_year = r3_est;
            n4_base = r3_eoy_m;
        end else if (r3_eoy_p < EOY_W'(r3_idx)) begin
            n4_year = r3_est + YEAR_W'(2);
            n4_base = r3_eoy_p;
        end else begin
            n4_year = r3_est + YEAR_W'(1);
            n4_base = r3_eoy_0;
        end
        if (r3_wt) begin
            n4_hour = r3_hour;
            n4_min  = MIN_W'(r3_mtot - MTOT_W'(r3_hour) * MTOT_W'(60));
            n4_sec  = r3_sec;
        end else begin
            n4_hour = HOUR_W'(12);
            n4_min  = '0;
            n4_sec  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r4_year <= n4_year;
            r4_yday <= YDAY_W'(EOY_W'(r3_idx) - n4_base);
            r4_hour <= n4_hour;
            r4_min  <= n4_min;
            r4_sec  <= n4_sec;
            r4_wday <= r3_wday;
            r4_zero <= r3_zero;
        end
    end

    // stage 5: leap year, early-year case, shifted day number
    logic              n5_leap;
    logic              r5_early;
    logic [YDAY_W-1:0] r5_n;
    logic [YEAR_W-1:0] r5_year;
    logic [YDAY_W-1:0] r5_yday;
    logic [HOUR_W-1:0] r5_hour;
    logic [MIN_W-1:0]  r5_min;
    logic [SEC_W-1:0]  r5_sec;
    logic [WDAY_W-1:0] r5_wday;
    logic              r5_zero;

    assign n5_leap = is_leap(r4_year);

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r5_early <= (r4_yday <= YDAY_W'(59)) || (n5_leap && r4_yday == YDAY_W'(60));
            r5_n     <= r4_yday - YDAY_W'(n5_leap);
            r5_year  <= r4_year;
            r5_yday  <= r4_yday;
            r5_hour  <= r4_hour;
            r5_min   <= r4_min;
            r5_sec   <= r4_sec;
            r5_wday  <= r4_wday;
            r5_zero  <= r4_zero;
        end
    end

    // stage 6: month
    logic [11:0]       n6_t;
    logic [23:0]       n6_mprod;
    logic [MON_W-1:0]  n6_month;
    logic [MON_W-1:0]  r6_month;
    logic [8:0]        r6_rem;
    logic [MDAY_W-1:0] r6_mday_early;
    logic              r6_early;
    logic [YEAR_W-1:0] r6_year;
    logic [YDAY_W-1:0] r6_yday;
    logic [HOUR_W-1:0] r6_hour;
    logic [MIN_W-1:0]  r6_min;
    logic [SEC_W-1:0]  r6_sec;
    logic [WDAY_W-1:0] r6_wday;
    logic              r6_zero;

    assign n6_t     = 12'(r5_n) * 12'd10 + 12'd323;
    assign n6_mprod = 24'(n6_t) * 24'(DIV306_MUL);
    assign n6_month = r5_early ? ((r5_yday > YDAY_W'(31)) ? MON_W'(2) : MON_W'(1)) :
                      n6_mprod[23:20];

    always_ff @(posedge i_clk) begin
        if (w_en[5]) begin
            r6_month      <= n6_month;
            r6_rem        <= 9'(n6_t + 12'd10 - 12'(n6_month) * 12'd306);
            r6_mday_early <= (r5_yday > YDAY_W'(31)) ? MDAY_W'(r5_yday - YDAY_W'(31)) :
                             MDAY_W'(r5_yday);
            r6_early      <= r5_early;
            r6_year       <= r5_year;
            r6_yday       <= r5_yday;
            r6_hour       <= r5_hour;
            r6_min        <= r5_min;
            r6_sec        <= r5_sec;
            r6_wday       <= r5_wday;
            r6_zero       <= r5_zero;
        end
    end

    // stage 7: day of month, blank date for index zero
    logic [15:0]       n7_dprod;
    logic [MDAY_W-1:0] n7_mday;
    logic [YEAR_W-1:0] r7_year;
    logic [MON_W-1:0]  r7_month;
    logic [MDAY_W-1:0] r7_mday;
    logic [YDAY_W-1:0] r7_yday;
    logic [WDAY_W-1:0] r7_wday;
    logic [HOUR_W-1:0] r7_hour;
    logic [MIN_W-1:0]  r7_min;
    logic [SEC_W-1:0]  r7_sec;

    assign n7_dprod = 16'(r6_rem) * 16'(DIV10_MUL);
    assign n7_mday  = r6_early ? r6_mday_early : n7_dprod[15:11];

    always_ff @(posedge i_clk) begin
        if (w_en[6]) begin
            r7_year  <= r6_zero ? '0 : r6_year;
            r7_month <= r6_zero ? '0 : r6_month;
            r7_mday  <= r6_zero ? '0 : n7_mday;
            r7_yday  <= r6_zero ? '0 : r6_yday;
            r7_wday  <= r6_zero ? '0 : r6_wday;
            r7_hour  <= r6_hour;
            r7_min   <= r6_min;
            r7_sec   <= r6_sec;
        end
    end

    assign o_result.valid        = r_v[NSTG-1];
    assign o_result.year         = r7_year;
    assign o_result.month        = r7_month;
    assign o_result.day_of_month = r7_mday;
    assign o_result.day_of_year  = r7_yday;
    assign o_result.weekday      = r7_wday;
    assign o_result.hour         = r7_hour;
    assign o_result.minute       = r7_min;
    assign o_result.second       = r7_sec;

    `ASSERT_NEXT(a_enter, i_clk, i_rst_n, i_item.valid && i_item.ready, r_v[0])
    `ASSERT_IMPLY(a_month, i_clk, i_rst_n, o_result.valid && o_result.year != '0,
                  o_result.month >= MON_W'(1) && o_result.month <= MON_W'(12))
    `ASSERT_IMPLY(a_mday, i_clk, i_rst_n, o_result.valid && o_result.day_of_year != '0,
                  o_result.day_of_month >= MDAY_W'(1) && o_result.day_of_month <= MDAY_W'(31))
    `ASSERT_IMPLY(a_clock, i_clk, i_rst_n, o_result.valid,
                  o_result.hour <= HOUR_W'(23) && o_result.minute <= MIN_W'(59) &&
                  o_result.second <= SEC_W'(59))

endmodule
